@@ rtl/ssgf_pkg.sv @@
// shared types and constants of the spherical shell gaussian field core
// used by ssgf_poly, ssgf_prep, ssgf_out and the top core; no dependencies
`timescale 1ns / 1ps

package ssgf_pkg;

	localparam logic [30:0] ONE_Q30    = 31'd1073741824;
	localparam logic [29:0] LN2_Q30    = 30'd744261118;
	localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
	// floor(2^46 / LN2_Q30): a * 2^14 / ln2 estimated as (a * LN2_RECIP) >> 32
	localparam logic [16:0] LN2_RECIP  = 17'd94548;
	// exp cutoff, u >= 6.0 in the unshifted Q32 product
	localparam logic [65:0] EXP_CUT    = 66'd25769803776;

	localparam int POLY_EXP = 0;
	localparam int POLY_SIN = 1;

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_DECAY  = 2'd1,
		REG_FREQ   = 2'd2,
		REG_PHASE  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [30:0] radius;
		logic [30:0] decay;
		logic [30:0] freq;
		logic [15:0] phase;
	} cfg_t;

	typedef struct packed {
		logic [5:0]  n;
		logic [31:0] t2;
		logic [30:0] th;
		logic        neg;
		logic        uf;
	} exp_side_t;

	typedef struct packed {
		logic [30:0] pe;
		logic [5:0]  n;
		logic [30:0] th;
		logic        neg;
		logic        uf;
	} sin_side_t;

	function automatic int poly_terms(int sel);
		return (sel == POLY_EXP) ? 12 : 5;
	endfunction

	// horner divisors, innermost term first
	function automatic int poly_div(int sel, int i);
		int d;
		d = 6;
		if (sel == POLY_EXP) begin
			d = 12 - i;
		end else begin
			case (i)
				0: d = 110;
				1: d = 72;
				2: d = 42;
				3: d = 20;
				default: d = 6;
			endcase
		end
		return d;
	endfunction

endpackage

@@ rtl/ssgf_if.sv @@
// valid/ready channel interfaces for the point input and the field output
// depends on nothing
`timescale 1ns / 1ps

interface ssgf_in_if #(parameter int CW = 32);
	logic              valid;
	logic              ready;
	logic signed [CW-1:0] rel_x;
	logic signed [CW-1:0] rel_y;
	logic signed [CW-1:0] rel_z;

	modport source(output valid, output rel_x, output rel_y, output rel_z, input ready);
	modport sink(input valid, input rel_x, input rel_y, input rel_z, output ready);
endinterface

interface ssgf_out_if #(parameter int OW = 16);
	logic              valid;
	logic              ready;
	logic signed [OW-1:0] field_value;

	modport source(output valid, output field_value, input ready);
	modport sink(input valid, input field_value, output ready);
endinterface

@@ rtl/ssgf_poly.sv @@
// pipelined horner series p = 1 - ((p * op) >> 30) / k, three stages per term
// depends on ssgf_pkg for the divisor lists and fixed point constants
`timescale 1ns / 1ps

module ssgf_poly #(
	parameter int SEL    = 0,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       in_op,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [30:0]       out_p,
	output logic [SIDE_W-1:0] out_side
);

	localparam int NT = ssgf_pkg::poly_terms(SEL);
	localparam int NS = 3 * NT;

	logic [NS-1:0] v;
	logic [NS:0]   go;
	logic [NS-1:0] vin;

	logic [31:0]       t_s1    [NT];
	logic [31:0]       op_s1   [NT];
	logic [SIDE_W-1:0] side_s1 [NT];
	logic [31:0]       t_s2    [NT];
	logic [31:0]       q_s2    [NT];
	logic [31:0]       op_s2   [NT];
	logic [SIDE_W-1:0] side_s2 [NT];
	logic [30:0]       p_s3    [NT];
	logic [31:0]       op_s3   [NT];
	logic [SIDE_W-1:0] side_s3 [NT];

	assign go[NS] = out_ready;
	assign vin    = {v[NS-2:0], in_valid};

	for (genvar i = 0; i < NS; i++) begin : g_ctl
		assign go[i] = !v[i] || go[i+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[i] <= 1'b0;
			end else if (go[i]) begin
				v[i] <= vin[i];
			end
		end
	end

	for (genvar j = 0; j < NT; j++) begin : g_term
		localparam int DIV = ssgf_pkg::poly_div(SEL, j);
		localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DIV);

		logic [30:0]       p_in;
		logic [31:0]       op_in;
		logic [SIDE_W-1:0] side_in;
		logic [62:0]       pr;
		logic [64:0]       qr;
		logic [31:0]       qk;
		logic [31:0]       rm;
		logic [31:0]       qf;

		if (j == 0) begin : g_first
			assign p_in    = ssgf_pkg::ONE_Q30;
			assign op_in   = in_op;
			assign side_in = in_side;
		end else begin : g_next
			assign p_in    = p_s3[j-1];
			assign op_in   = op_s3[j-1];
			assign side_in = side_s3[j-1];
		end

		assign pr = 63'(p_in) * 63'(op_in);
		assign qr = 65'(t_s1[j]) * 65'(RECIP);
		// reciprocal estimate is low by at most one
		assign qk = 32'(q_s2[j] * 32'(DIV));
		assign rm = t_s2[j] - qk;
		assign qf = (rm >= 32'(DIV)) ? q_s2[j] + 32'd1 : q_s2[j];

		always_ff @(posedge clk) begin
			if (go[3*j]) begin
				t_s1[j]    <= pr[61:30];
				op_s1[j]   <= op_in;
				side_s1[j] <= side_in;
			end
			if (go[3*j+1]) begin
				t_s2[j]    <= t_s1[j];
				q_s2[j]    <= qr[63:32];
				op_s2[j]   <= op_s1[j];
				side_s2[j] <= side_s1[j];
			end
			if (go[3*j+2]) begin
				p_s3[j]    <= ssgf_pkg::ONE_Q30 - 31'(qf);
				op_s3[j]   <= op_s2[j];
				side_s3[j] <= side_s2[j];
			end
		end
	end

	assign in_ready  = go[0];
	assign out_valid = v[NS-1];
	assign out_p     = p_s3[NT-1];
	assign out_side  = side_s3[NT-1];

endmodule

@@ rtl/ssgf_radius.sv @@
// radius pipeline: magnitudes, squares, 2-bit-per-step integer square root, d = r - radius
// depends on nothing outside this file
`timescale 1ns / 1ps

module ssgf_radius #(
	parameter int CW = 32,
	localparam int KMAX = (CW > 32) ? CW - 32 : 0,
	localparam int DW = 33 + KMAX
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [CW-1:0] in_x,
	input  logic signed [CW-1:0] in_y,
	input  logic signed [CW-1:0] in_z,
	input  logic [30:0]          radius,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [DW-1:0] out_d
);

	localparam int MW   = (CW > 32) ? CW : 32;
	localparam int KW   = $clog2(KMAX + 2);
	localparam int RW   = 32 + KMAX;
	localparam int NSQ  = 16;
	localparam int NSTG = NSQ + 4;
	localparam logic [MW-1:0] LIM = MW'(64'd1 << 31);

	logic [NSTG-1:0] v;
	logic [NSTG:0]   go;
	logic [NSTG-1:0] vin;

	logic [CW-1:0] crd [3];
	logic [MW-1:0] mag [3];
	logic [KW-1:0] k_c;
	logic [31:0]   nm  [3];

	logic [MW-1:0] mag_s1 [3];
	logic [KW-1:0] k_s1;
	logic [63:0]   sq_s2  [3];
	logic [KW-1:0] k_s2;
	logic [63:0]   sum_s3;
	logic [KW-1:0] k_s3;

	logic [33:0]   rem_sn  [NSQ];
	logic [31:0]   root_sn [NSQ];
	logic [63:0]   vb_sn   [NSQ];
	logic [KW-1:0] k_sn    [NSQ];

	logic [RW-1:0]        rr;
	logic signed [DW-1:0] d_s20;

	assign go[NSTG] = out_ready;
	assign vin      = {v[NSTG-2:0], in_valid};

	for (genvar i = 0; i < NSTG; i++) begin : g_ctl
		assign go[i] = !v[i] || go[i+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[i] <= 1'b0;
			end else if (go[i]) begin
				v[i] <= vin[i];
			end
		end
	end

	assign crd[0] = in_x;
	assign crd[1] = in_y;
	assign crd[2] = in_z;

	for (genvar i = 0; i < 3; i++) begin : g_axis
		assign mag[i] = MW'(crd[i][CW-1] ? (~crd[i] + 1'b1) : crd[i]);
		assign nm[i]  = 32'(mag_s1[i] >> k_s1);
	end

	// smallest common shift that brings every magnitude to 2^31 or below
	always_comb begin
		k_c = '0;
		for (int j = KMAX; j >= 0; j--) begin
			if ((mag[0] >> j) <= LIM && (mag[1] >> j) <= LIM && (mag[2] >> j) <= LIM) begin
				k_c = KW'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go[0]) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag[i];
			end
			k_s1 <= k_c;
		end
		if (go[1]) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= 64'(nm[i]) * 64'(nm[i]);
			end
			k_s2 <= k_s1;
		end
		if (go[2]) begin
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			k_s3   <= k_s2;
		end
	end

	for (genvar m = 0; m < NSQ; m++) begin : g_sqrt
		logic [33:0]   rem_i;
		logic [31:0]   root_i;
		logic [63:0]   vb_i;
		logic [KW-1:0] k_i;
		logic [35:0]   r1;
		logic [35:0]   r2;
		logic [35:0]   t1;
		logic [35:0]   t2;
		logic [31:0]   o1;
		logic [31:0]   o2;

		if (m == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign vb_i   = sum_s3;
			assign k_i    = k_s3;
		end else begin : g_next
			assign rem_i  = rem_sn[m-1];
			assign root_i = root_sn[m-1];
			assign vb_i   = vb_sn[m-1];
			assign k_i    = k_sn[m-1];
		end

		always_comb begin
			r1 = {rem_i, vb_i[63:62]};
			t1 = {2'b00, root_i, 2'b01};
			if (r1 >= t1) begin
				r1 = r1 - t1;
				o1 = {root_i[30:0], 1'b1};
			end else begin
				o1 = {root_i[30:0], 1'b0};
			end
			r2 = {r1[33:0], vb_i[61:60]};
			t2 = {2'b00, o1, 2'b01};
			if (r2 >= t2) begin
				r2 = r2 - t2;
				o2 = {o1[30:0], 1'b1};
			end else begin
				o2 = {o1[30:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (go[3+m]) begin
				rem_sn[m]  <= r2[33:0];
				root_sn[m] <= o2;
				vb_sn[m]   <= vb_i << 4;
				k_sn[m]    <= k_i;
			end
		end
	end

	assign rr = RW'(root_sn[NSQ-1]) << k_sn[NSQ-1];

	always_ff @(posedge clk) begin
		if (go[NSTG-1]) begin
			d_s20 <= $signed({1'b0, rr}) - $signed(DW'(radius));
		end
	end

	assign in_ready  = go[0];
	assign out_valid = v[NSTG-1];
	assign out_d     = d_s20;

endmodule

@@ rtl/ssgf_prep.sv @@
// argument preparation: gaussian exponent with range reduction, phase fold, sine angle
// depends on ssgf_pkg for constants and the side struct
`timescale 1ns / 1ps

module ssgf_prep #(
	parameter int DW = 33
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [DW-1:0]  in_d,
	input  ssgf_pkg::cfg_t        cfg,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [29:0]           out_rem,
	output ssgf_pkg::exp_side_t   out_side
);

	localparam int AEW  = (DW > 35) ? DW : 35;
	localparam int NSTG = 6;

	logic [NSTG-1:0] v;
	logic [NSTG:0]   go;
	logic [NSTG-1:0] vin;

	logic [DW-1:0]  ad;
	logic [AEW-1:0] ad_e;
	logic           big;
	logic [48:0]    lo;
	logic [47:0]    hi;
	logic [62:0]    twp;

	logic [48:0] lo_s1;
	logic [47:0] hi_s1;
	logic        big_s1;
	logic [31:0] tw_s1;

	logic [65:0] full;
	logic        uf;
	logic [31:0] turn;
	logic [1:0]  qd;
	logic [30:0] xf;

	logic [18:0] u_s2;
	logic [30:0] x_s2;
	logic        neg_s2;
	logic        uf_s2;

	logic [37:0] usq;
	logic [61:0] thp;
	logic [21:0] a_s3;
	logic [30:0] th_s3;
	logic        neg_s3;
	logic        uf_s3;

	logic [38:0] np;
	logic [61:0] thsq;
	logic [21:0] a_s4;
	logic [5:0]  ne_s4;
	logic [31:0] t2_s4;
	logic [30:0] th_s4;
	logic        neg_s4;
	logic        uf_s4;

	logic [35:0] nl_s5;
	logic [35:0] aq_s5;
	logic [5:0]  ne_s5;
	logic [31:0] t2_s5;
	logic [30:0] th_s5;
	logic        neg_s5;
	logic        uf_s5;

	logic [35:0] r0;
	logic [29:0] rem_s6;
	logic [5:0]  n_s6;
	logic [31:0] t2_s6;
	logic [30:0] th_s6;
	logic        neg_s6;
	logic        uf_s6;

	assign go[NSTG] = out_ready;
	assign vin      = {v[NSTG-2:0], in_valid};

	for (genvar i = 0; i < NSTG; i++) begin : g_ctl
		assign go[i] = !v[i] || go[i+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[i] <= 1'b0;
			end else if (go[i]) begin
				v[i] <= vin[i];
			end
		end
	end

	// |d| * decay split in two partial products; any |d| of 2^35 or more underflows unless decay is zero
	assign ad   = in_d[DW-1] ? DW'(-in_d) : DW'(in_d);
	assign ad_e = AEW'(ad);
	assign big  = (ad_e >> 35) != '0;
	assign lo   = 49'(ad_e[17:0]) * 49'(cfg.decay);
	assign hi   = 48'(ad_e[34:18]) * 48'(cfg.decay);
	assign twp  = 63'(cfg.freq) * 63'(in_d[31:0]);

	assign full = (66'(hi_s1) << 18) + 66'(lo_s1);
	assign uf   = big_s1 || (full >= ssgf_pkg::EXP_CUT);
	assign turn = tw_s1 + {cfg.phase, 16'h0000};
	// cos is sin a quarter turn ahead
	assign qd   = turn[31:30] + 2'd1;
	assign xf   = qd[0] ? ssgf_pkg::ONE_Q30 - 31'(turn[29:0]) : 31'(turn[29:0]);

	assign usq  = 38'(u_s2) * 38'(u_s2);
	assign thp  = 62'(x_s2) * 62'(ssgf_pkg::HALFPI_Q30);
	assign np   = 39'(a_s3) * 39'(ssgf_pkg::LN2_RECIP);
	assign thsq = 62'(th_s3) * 62'(th_s3);
	assign r0   = aq_s5 - nl_s5;

	always_ff @(posedge clk) begin
		if (go[0]) begin
			lo_s1  <= lo;
			hi_s1  <= hi;
			big_s1 <= big && (cfg.decay != '0);
			tw_s1  <= twp[31:0];
		end
		if (go[1]) begin
			u_s2   <= uf ? '0 : full[34:16];
			x_s2   <= xf;
			neg_s2 <= qd[1];
			uf_s2  <= uf;
		end
		if (go[2]) begin
			a_s3   <= usq[37:16];
			th_s3  <= thp[60:30];
			neg_s3 <= neg_s2;
			uf_s3  <= uf_s2;
		end
		if (go[3]) begin
			a_s4   <= a_s3;
			ne_s4  <= np[37:32];
			t2_s4  <= thsq[61:30];
			th_s4  <= th_s3;
			neg_s4 <= neg_s3;
			uf_s4  <= uf_s3;
		end
		if (go[4]) begin
			nl_s5  <= 36'(ne_s4) * 36'(ssgf_pkg::LN2_Q30);
			aq_s5  <= {a_s4, 14'h0000};
			ne_s5  <= ne_s4;
			t2_s5  <= t2_s4;
			th_s5  <= th_s4;
			neg_s5 <= neg_s4;
			uf_s5  <= uf_s4;
		end
		if (go[5]) begin
			// quotient estimate may be one short
			if (r0 >= 36'(ssgf_pkg::LN2_Q30)) begin
				rem_s6 <= 30'(r0 - 36'(ssgf_pkg::LN2_Q30));
				n_s6   <= ne_s5 + 6'd1;
			end else begin
				rem_s6 <= 30'(r0);
				n_s6   <= ne_s5;
			end
			t2_s6  <= t2_s5;
			th_s6  <= th_s5;
			neg_s6 <= neg_s5;
			uf_s6  <= uf_s5;
		end
	end

	assign in_ready     = go[0];
	assign out_valid    = v[NSTG-1];
	assign out_rem      = rem_s6;
	assign out_side.n   = n_s6;
	assign out_side.t2  = t2_s6;
	assign out_side.th  = th_s6;
	assign out_side.neg = neg_s6;
	assign out_side.uf  = uf_s6;

endmodule

@@ rtl/ssgf_out.sv @@
// output stages: sine finish, exp scaling, product, rounding, sign and saturation
// depends on ssgf_pkg for the side struct and constants
`timescale 1ns / 1ps

module ssgf_out #(
	parameter int OW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [30:0]          in_p,
	input  ssgf_pkg::sin_side_t  in_side,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [OW-1:0] out_val
);

	localparam int NSTG = 3;
	localparam int SH   = 61 - OW;
	localparam int MW   = OW + 2;
	localparam logic [62:0]   RND  = 63'(64'd1 << (SH - 1));
	localparam logic [MW-1:0] VMAX = MW'((64'd1 << (OW - 1)) - 64'd1);

	logic [NSTG-1:0] v;
	logic [NSTG:0]   go;
	logic [NSTG-1:0] vin;

	logic [61:0] sp;
	logic [31:0] s_s1;
	logic [30:0] e_s1;
	logic        neg_s1;
	logic        uf_s1;

	logic [62:0] prod_s2;
	logic        neg_s2;
	logic        uf_s2;

	logic [62:0]   msum;
	logic [MW-1:0] m;
	logic [MW-1:0] mc;
	logic [OW-1:0] val;
	logic [OW-1:0] field_s3;

	assign go[NSTG] = out_ready;
	assign vin      = {v[NSTG-2:0], in_valid};

	for (genvar i = 0; i < NSTG; i++) begin : g_ctl
		assign go[i] = !v[i] || go[i+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[i] <= 1'b0;
			end else if (go[i]) begin
				v[i] <= vin[i];
			end
		end
	end

	assign sp   = 62'(in_p) * 62'(in_side.th);
	assign msum = prod_s2 + RND;
	assign m    = MW'(msum >> SH);

	always_comb begin
		mc  = '0;
		val = '0;
		if (!uf_s2) begin
			if (neg_s2) begin
				mc  = (m > VMAX + 1'b1) ? VMAX + 1'b1 : m;
				val = OW'(~mc + 1'b1);
			end else begin
				mc  = (m > VMAX) ? VMAX : m;
				val = OW'(mc);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go[0]) begin
			s_s1   <= sp[61:30];
			e_s1   <= in_side.pe >> in_side.n;
			neg_s1 <= in_side.neg;
			uf_s1  <= in_side.uf;
		end
		if (go[1]) begin
			prod_s2 <= 63'(e_s1) * 63'(s_s1);
			neg_s2  <= neg_s1;
			uf_s2   <= uf_s1;
		end
		if (go[2]) begin
			field_s3 <= val;
		end
	end

	assign in_ready  = go[0];
	assign out_valid = v[NSTG-1];
	assign out_val   = $signed(field_s3);

	a_exp_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		v[0] |-> e_s1 <= ssgf_pkg::ONE_Q30)
		else $error("scaled exp above one");

	a_uf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v[1] && uf_s2 && go[2] |=> v[2] && field_s3 == '0)
		else $error("underflowed point gave a nonzero field");

	a_pos_sign: assert property (@(posedge clk) disable iff (!arst_n)
		v[1] && !neg_s2 && go[2] |=> !field_s3[OW-1])
		else $error("positive cosine half gave a negative field");

endmodule

@@ rtl/spherical_shell_gaussian_field_core.sv @@
// Spherical shell Gaussian field core: takes one grid point offset per cycle and returns
// exp(-(|r| - radius)^2 * decay^2) * cos(2*pi*(freq*(|r| - radius) + phase)) in signed
// Q1.(OUT_WIDTH-1), one point per clock unless the output stalls. Path: radius and
// square root pipeline, argument preparation, 12 term exp series, 5 term sine series,
// output stages. Every stage has its own valid bit, so a stalled output only holds the
// stages that are full. The user must write configuration registers through
// cfg_we/cfg_idx/cfg_data only while no point is in flight; the core does not check.
// depends on ssgf_pkg, ssgf_if, ssgf_radius, ssgf_prep, ssgf_poly, ssgf_out
`timescale 1ns / 1ps

module spherical_shell_gaussian_field_core #(
	parameter int COORD_WIDTH = 32,
	parameter int OUT_WIDTH   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [30:0]  cfg_data,
	ssgf_in_if.sink      in_ch,
	ssgf_out_if.source   out_ch
);

	localparam int DW = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1;
	localparam int EXP_SW = $bits(ssgf_pkg::exp_side_t);

	ssgf_pkg::cfg_t cfg_q;

	logic                 rad_valid;
	logic                 rad_ready;
	logic signed [DW-1:0] rad_d;

	logic                 prep_valid;
	logic                 prep_ready;
	logic [29:0]          prep_rem;
	ssgf_pkg::exp_side_t  prep_side;

	logic                 exp_valid;
	logic                 exp_ready;
	logic [30:0]          exp_p;
	logic [EXP_SW-1:0]    exp_side_bits;
	ssgf_pkg::exp_side_t  exp_side;
	ssgf_pkg::sin_side_t  sin_in_side;

	logic                 sin_valid;
	logic                 sin_ready;
	logic [30:0]          sin_p;
	logic [$bits(ssgf_pkg::sin_side_t)-1:0] sin_side_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius <= '0;
			cfg_q.decay  <= 31'd65536;
			cfg_q.freq   <= '0;
			cfg_q.phase  <= '0;
		end else if (cfg_we) begin
			unique case (ssgf_pkg::cfg_reg_t'(cfg_idx))
				ssgf_pkg::REG_RADIUS: cfg_q.radius <= cfg_data;
				ssgf_pkg::REG_DECAY:  cfg_q.decay  <= cfg_data;
				ssgf_pkg::REG_FREQ:   cfg_q.freq   <= cfg_data;
				ssgf_pkg::REG_PHASE:  cfg_q.phase  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ssgf_radius #(.CW(COORD_WIDTH)) u_radius (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_x      (in_ch.rel_x),
		.in_y      (in_ch.rel_y),
		.in_z      (in_ch.rel_z),
		.radius    (cfg_q.radius),
		.out_valid (rad_valid),
		.out_ready (rad_ready),
		.out_d     (rad_d)
	);

	ssgf_prep #(.DW(DW)) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rad_valid),
		.in_ready  (rad_ready),
		.in_d      (rad_d),
		.cfg       (cfg_q),
		.out_valid (prep_valid),
		.out_ready (prep_ready),
		.out_rem   (prep_rem),
		.out_side  (prep_side)
	);

	ssgf_poly #(.SEL(ssgf_pkg::POLY_EXP), .SIDE_W(EXP_SW)) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_valid),
		.in_ready  (prep_ready),
		.in_op     (32'(prep_rem)),
		.in_side   (prep_side),
		.out_valid (exp_valid),
		.out_ready (exp_ready),
		.out_p     (exp_p),
		.out_side  (exp_side_bits)
	);

	assign exp_side        = ssgf_pkg::exp_side_t'(exp_side_bits);
	assign sin_in_side.pe  = exp_p;
	assign sin_in_side.n   = exp_side.n;
	assign sin_in_side.th  = exp_side.th;
	assign sin_in_side.neg = exp_side.neg;
	assign sin_in_side.uf  = exp_side.uf;

	ssgf_poly #(.SEL(ssgf_pkg::POLY_SIN), .SIDE_W($bits(ssgf_pkg::sin_side_t))) u_sin (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (exp_valid),
		.in_ready  (exp_ready),
		.in_op     (exp_side.t2),
		.in_side   (sin_in_side),
		.out_valid (sin_valid),
		.out_ready (sin_ready),
		.out_p     (sin_p),
		.out_side  (sin_side_bits)
	);

	ssgf_out #(.OW(OUT_WIDTH)) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sin_valid),
		.in_ready  (sin_ready),
		.in_p      (sin_p),
		.in_side   (ssgf_pkg::sin_side_t'(sin_side_bits)),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_val   (out_ch.field_value)
	);

endmodule
